// ----- rtl/skfb_pkg.sv -----
// ----------------------------------------------------------------------------
// skfb_pkg: shared types and constants for the scalar Kalman filter bank
// Field widths, register reset values, register indexes and the sequencer
// state type.
// ----------------------------------------------------------------------------
`default_nettype none

package skfb_pkg;

   // filter count default
   localparam int CHANNELS_DEFAULT = 6;

   // field widths
   localparam int CHAN_W   = 3;
   localparam int SAMPLE_W = 16;
   localparam int EST_W    = 24;   // signed Q16.8
   localparam int VAR_W    = 32;   // unsigned Q16.16
   localparam int NOISE_W  = 24;   // unsigned Q8.16
   localparam int GAIN_W   = 17;   // unsigned Q1.16, 1.0 reachable

   // configuration port
   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_PROCESS_NOISE     = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEASUREMENT_NOISE = 1'd1;

   localparam logic [NOISE_W-1:0] PROCESS_NOISE_RESET     = 24'd1311;
   localparam logic [NOISE_W-1:0] MEASUREMENT_NOISE_RESET = 24'd131072;

   // restoring divider: one quotient bit per cycle
   localparam int DIV_STEPS = GAIN_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_DEN,
      ST_DIV,
      ST_MULX,
      ST_MULP,
      ST_WB
   } state_type;

endpackage

`default_nettype wire

// ----- rtl/scalar_kalman_filter_bank_unit.sv -----
// ----------------------------------------------------------------------------
// scalar_kalman_filter_bank_unit: bank of scalar constant-state Kalman filters
//
// Request channel (req_valid / req_stall, req_channel, req_sample) takes one
// signed integer sample for one filter. The response channel (rsp_valid /
// rsp_stall) returns the channel and the updated Q16.8 estimate, one response
// per request, in order.
// Each request passes from transfer to response valid through one memory
// read, the predicted variance and denominator, a restoring divider for the
// gain, two multiply states and a write-back state. One request is in work
// at a time: a new request is taken only once the previous one has left
// write-back, which waits while a stalled response holds the output register.
// A response waiting in the output register does not block the next request;
// a request reaching write-back while the previous response is still stalled
// waits there. Channels at or above CHANNELS leave the state alone and return
// an estimate of zero. Reset clears all estimates and variances (per-entry
// valid bits) and loads the reset noise values. Q and R are written through
// the csr port; the user must write them only while idle (not enforced).
// ----------------------------------------------------------------------------
`default_nettype none

module scalar_kalman_filter_bank_unit #(
   parameter int CHANNELS = skfb_pkg::CHANNELS_DEFAULT
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   // request
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [skfb_pkg::CHAN_W-1:0]           req_channel,
   input  wire logic signed [skfb_pkg::SAMPLE_W-1:0]  req_sample,
   // response
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [skfb_pkg::CHAN_W-1:0]                rsp_out_channel,
   output logic signed [skfb_pkg::EST_W-1:0]          rsp_estimate,
   // configuration
   input  wire logic                                  csr_write,
   input  wire logic [skfb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [skfb_pkg::NOISE_W-1:0]          csr_data
);

   import skfb_pkg::*;

   localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [6:0] CHAN_LIM = 7'(CHANNELS);

   // config registers
   logic [NOISE_W-1:0] q_ff;
   logic [NOISE_W-1:0] r_ff;

   // state memories
   logic [EST_W-1:0]    est_mem [CHANNELS];
   logic [VAR_W-1:0]    var_mem [CHANNELS];
   logic [CHANNELS-1:0] valid_ff;
   logic [EST_W-1:0]    est_rd_ff;
   logic [VAR_W-1:0]    var_rd_ff;
   logic                rd_valid_ff;

   // sequencer
   state_type              state_ff, state_in;
   logic [DIV_CNT_W-1:0]   cnt_ff;

   // item payload
   logic [CHAN_W-1:0]          chan_ff;
   logic [AW-1:0]              addr_ff;
   logic                       in_range_ff;
   logic signed [SAMPLE_W-1:0] sample_ff;
   logic signed [EST_W-1:0]    x_ff;
   logic [VAR_W-1:0]           pp_ff;
   logic [VAR_W:0]             den_ff;
   logic [VAR_W+1:0]           rem_ff;
   logic [GAIN_W-1:0]          quot_ff;
   logic signed [42:0]         prodx_ff;
   logic [48:0]                prodp_ff;
   logic signed [EST_W-1:0]    xn_ff;

   // response register
   logic                       rsp_valid_ff;
   logic [CHAN_W-1:0]          rsp_chan_ff;
   logic signed [EST_W-1:0]    rsp_est_ff;

   // datapath
   logic                       req_accept;
   logic                       req_in_range;
   logic                       wb_go;
   logic [VAR_W-1:0]           p_cur;
   logic [VAR_W:0]             pp_sum;
   logic [VAR_W-1:0]           pp_sat;
   logic [VAR_W:0]             den_sum;
   logic                       rem_ge;
   logic [VAR_W+1:0]           rem_sub;
   logic [VAR_W+1:0]           rem_sel;
   logic signed [24:0]         diff;
   logic signed [42:0]         prodx;
   logic signed [42:0]         round_sum;
   logic signed [26:0]         xn_full;
   logic [GAIN_W-1:0]          k_comp;
   logic [48:0]                prodp;
   logic [VAR_W-1:0]           p_new;

   assign req_stall    = (state_ff != ST_IDLE);
   assign req_accept   = req_valid && !req_stall;
   assign req_in_range = ({4'b0, req_channel} < CHAN_LIM);
   assign wb_go        = (state_ff == ST_WB) && (!rsp_valid_ff || !rsp_stall);

   // predicted variance, saturating
   assign p_cur   = rd_valid_ff ? var_rd_ff : '0;
   assign pp_sum  = {1'b0, p_cur} + {9'b0, q_ff};
   assign pp_sat  = pp_sum[VAR_W] ? '1 : pp_sum[VAR_W-1:0];
   assign den_sum = {1'b0, pp_ff} + {9'b0, r_ff};

   // restoring divide step; zero denominator forces zero gain
   assign rem_ge  = (den_ff != '0) && (rem_ff >= {1'b0, den_ff});
   assign rem_sub = rem_ff - {1'b0, den_ff};
   assign rem_sel = rem_ge ? rem_sub : rem_ff;

   // estimate update
   assign diff      = 25'($signed({sample_ff, 8'b0})) - 25'(x_ff);
   assign prodx     = $signed({1'b0, quot_ff}) * diff;
   assign round_sum = prodx_ff + 43'sd32768;
   assign xn_full   = 27'(x_ff) + round_sum[42:16];

   // variance update
   assign k_comp = 17'd65536 - quot_ff;
   assign prodp  = {32'b0, k_comp} * {17'b0, pp_ff};
   assign p_new  = prodp_ff[47:16];

   // config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff <= PROCESS_NOISE_RESET;
         r_ff <= MEASUREMENT_NOISE_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_PROCESS_NOISE:     q_ff <= csr_data;
            CSR_MEASUREMENT_NOISE: r_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // memories: read on transfer, write at write-back
   always_ff @(posedge clock) begin
      if (req_accept && req_in_range) begin
         est_rd_ff <= est_mem[AW'(req_channel)];
         var_rd_ff <= var_mem[AW'(req_channel)];
      end
      if (wb_go && in_range_ff) begin
         est_mem[addr_ff] <= xn_ff;
         var_mem[addr_ff] <= p_new;
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (req_accept && req_in_range) begin
            rd_valid_ff <= valid_ff[AW'(req_channel)];
         end
         if (wb_go && in_range_ff) begin
            valid_ff[addr_ff] <= 1'b1;
         end
      end
   end

   // sequencer state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (req_accept) state_in = ST_READ;
         ST_READ: state_in = in_range_ff ? ST_DEN : ST_WB;
         ST_DEN:  state_in = ST_DIV;
         ST_DIV:  if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) state_in = ST_MULX;
         ST_MULX: state_in = ST_MULP;
         ST_MULP: state_in = ST_WB;
         ST_WB:   if (wb_go) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               chan_ff     <= req_channel;
               addr_ff     <= AW'(req_channel);
               in_range_ff <= req_in_range;
               sample_ff   <= req_sample;
            end
         end
         ST_READ: begin
            x_ff  <= rd_valid_ff ? est_rd_ff : '0;
            pp_ff <= pp_sat;
         end
         ST_DEN: begin
            den_ff  <= den_sum;
            rem_ff  <= {2'b0, pp_ff};
            quot_ff <= '0;
            cnt_ff  <= '0;
         end
         ST_DIV: begin
            rem_ff  <= {rem_sel[VAR_W:0], 1'b0};
            quot_ff <= {quot_ff[GAIN_W-2:0], rem_ge};
            cnt_ff  <= cnt_ff + 1'b1;
         end
         ST_MULX: begin
            prodx_ff <= prodx;
         end
         ST_MULP: begin
            prodp_ff <= prodp;
            xn_ff    <= xn_full[EST_W-1:0];
         end
         default: ;
      endcase
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (wb_go) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (wb_go) begin
         rsp_chan_ff <= chan_ff;
         rsp_est_ff  <= in_range_ff ? xn_ff : '0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_chan_ff;
   assign rsp_estimate    = rsp_est_ff;

   // checks
   a_accept_idle: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_READ)
      else $error("request transfer did not start a read");

   a_rsp_from_wb: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_WB)
      else $error("response raised outside write-back");

   a_gain_max: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MULX |-> quot_ff <= 17'd65536)
      else $error("gain above one");

   a_var_shrinks: assert property (@(posedge clock) disable iff (reset)
      (wb_go && in_range_ff) |-> p_new <= pp_ff)
      else $error("updated variance exceeds predicted variance");

endmodule

`default_nettype wire
